// ===== rtl/two_class_peak_level_centroid_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the two-class peak-level centroid block
// Each macro expects clk and rst_n in scope; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef TWO_CLASS_PEAK_LEVEL_CENTROID_DEFINES_SVH
`define TWO_CLASS_PEAK_LEVEL_CENTROID_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TCPLC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define TCPLC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TCPLC_ASSERT_IMP(lbl, ante, cons, msg)
`define TCPLC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/tcplc_pkg.sv =====
// ---------------------------------------------------------------------------
// tcplc_pkg
// Types, constants and codes shared by the centroid block.
// ---------------------------------------------------------------------------
`default_nettype none

package tcplc_pkg;

  localparam int COORD_BITS_DEF = 11;
  localparam int NUM_CLASSES    = 2;
  localparam int LEVEL_BITS     = 5;
  localparam int LEVEL_SHIFT    = 3;
  localparam int OUT_BITS       = 11;
  localparam int CFG_BITS       = 12;
  localparam int NUM_JOBS       = 4;
  localparam int JOB_BITS       = 2;

  localparam logic [7:0]            BLUE_SPLIT  = 8'd128;
  localparam logic [LEVEL_BITS-1:0] PEAK_RESET  = LEVEL_BITS'(1);
  localparam logic [CFG_BITS-1:0]   FW_RESET    = CFG_BITS'(640);
  localparam logic [JOB_BITS-1:0]   LAST_JOB    = JOB_BITS'(NUM_JOBS - 1);

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_PIX,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } pix_t;

  typedef struct packed {
    logic                first_found;
    logic [OUT_BITS-1:0] first_col;
    logic [OUT_BITS-1:0] first_row;
    logic                second_found;
    logic [OUT_BITS-1:0] second_col;
    logic [OUT_BITS-1:0] second_row;
  } res_t;

  // job code: upper bit class, lower bit axis (0 column, 1 row)
  typedef struct packed {
    logic                pix_en;
    logic                div_start;
    logic                res_load;
    logic                out_load;
    logic                frame_clear;
    logic [JOB_BITS-1:0] job;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/two_class_peak_level_centroid.sv =====
// ---------------------------------------------------------------------------
// two_class_peak_level_centroid: top level
// Throughput: one pixel per cycle within a frame.
// After the last pixel, four divisions of 3*COORD_BITS+1 steps each run in turn
// on one shared divider before the result word is loaded.
// Reset: synchronous, active low; width 640, counters and sums cleared.
// ---------------------------------------------------------------------------
`default_nettype none

`include "two_class_peak_level_centroid_defines.svh"

module two_class_peak_level_centroid
  import tcplc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire pix_t                in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output res_t                     out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire cfg_reg_t            cfg_index,
  input  wire logic [CFG_BITS-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  tcplc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_last   (in_data.last_pixel),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcplc_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .pix       (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (out_data)
  );

  `TCPLC_ASSERT_NXT(a_busy_after_last, in_valid && in_ready && in_data.last_pixel, !in_ready, "pixel taken while frame result pending")
  `TCPLC_ASSERT_IMP(a_word_from_busy, $rose(out_valid), $past(!in_ready), "result word raised during pixel intake")
  `TCPLC_ASSERT_IMP(a_first_empty, out_valid && !out_data.first_found, out_data.first_col == '0 && out_data.first_row == '0, "class one absent but mean nonzero")
  `TCPLC_ASSERT_IMP(a_second_empty, out_valid && !out_data.second_found, out_data.second_col == '0 && out_data.second_row == '0, "class two absent but mean nonzero")

endmodule

`default_nettype wire

// ===== rtl/tcplc_div.sv =====
// ---------------------------------------------------------------------------
// tcplc_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module tcplc_div
  import tcplc_pkg::*;
#(
  parameter int DVD_BITS = 34,
  parameter int DVS_BITS = 23
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [DVD_BITS-1:0] dividend,
  input  wire logic [DVS_BITS-1:0] divisor,
  output logic                     done,
  output logic [DVD_BITS-1:0]      quotient
);

  localparam int CNT_W = $clog2(DVD_BITS + 1);

  logic [DVD_BITS-1:0] quo_r;
  logic [DVS_BITS-1:0] rem_r;
  logic [DVS_BITS-1:0] dvs_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic                done_r;

  logic [DVS_BITS:0]   trial;
  logic [DVS_BITS:0]   diff;
  logic                ge;
  logic [DVS_BITS-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[DVD_BITS-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
      cnt_r <= CNT_W'(DVD_BITS);
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_BITS-2:0], ge};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== rtl/tcplc_dp.sv =====
// ---------------------------------------------------------------------------
// tcplc_dp
// Raster counters, per-class peak tracking and sums, divider and result word.
// ---------------------------------------------------------------------------
`default_nettype none

module tcplc_dp
  import tcplc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dp_cmd_t             cmd,
  output dp_sts_t                  sts,
  input  wire pix_t                pix,
  input  wire logic                cfg_we,
  input  wire cfg_reg_t            cfg_index,
  input  wire logic [CFG_BITS-1:0] cfg_data,
  output res_t                     res
);

  localparam int CNT_BITS = 2 * COORD_BITS + 1;
  localparam int SUM_BITS = 3 * COORD_BITS + 1;
  localparam int CMP_BITS = (COORD_BITS + 1 > CFG_BITS) ? COORD_BITS + 1 : CFG_BITS;

  logic [CFG_BITS-1:0]   frame_width_r;
  logic [COORD_BITS-1:0] col_r;
  logic [COORD_BITS-1:0] row_r;
  logic [LEVEL_BITS-1:0] peak_r    [NUM_CLASSES];
  logic [SUM_BITS-1:0]   col_sum_r [NUM_CLASSES];
  logic [SUM_BITS-1:0]   row_sum_r [NUM_CLASSES];
  logic [CNT_BITS-1:0]   cnt_r     [NUM_CLASSES];
  logic [OUT_BITS-1:0]   mean_r    [NUM_JOBS];
  res_t                  res_r;

  logic [LEVEL_BITS-1:0] lvl_red;
  logic [LEVEL_BITS-1:0] lvl_green;
  logic [LEVEL_BITS-1:0] lvl;
  logic                  cls;
  logic [COORD_BITS:0]   col_inc;
  logic                  col_wrap;
  logic [SUM_BITS-1:0]   col_ext;
  logic [SUM_BITS-1:0]   row_ext;
  logic [SUM_BITS-1:0]   dividend;
  logic [CNT_BITS-1:0]   divisor;
  logic [SUM_BITS-1:0]   quotient;
  logic                  div_done;
  logic                  found0;
  logic                  found1;

  always_comb begin
    lvl_red   = LEVEL_BITS'(pix.red >> LEVEL_SHIFT);
    lvl_green = LEVEL_BITS'(pix.green >> LEVEL_SHIFT);
    lvl       = (lvl_red > lvl_green) ? lvl_red : lvl_green;
    cls       = pix.blue >= BLUE_SPLIT;
    col_inc   = {1'b0, col_r} + (COORD_BITS+1)'(1);
    col_wrap  = CMP_BITS'(col_inc) >= CMP_BITS'(frame_width_r);
    col_ext   = SUM_BITS'(col_r);
    row_ext   = SUM_BITS'(row_r);
    dividend  = cmd.job[0] ? (cmd.job[1] ? row_sum_r[1] : row_sum_r[0])
                           : (cmd.job[1] ? col_sum_r[1] : col_sum_r[0]);
    divisor   = cmd.job[1] ? cnt_r[1] : cnt_r[0];
    found0    = cnt_r[0] != '0;
    found1    = cnt_r[1] != '0;
  end

  tcplc_div #(
    .DVD_BITS (SUM_BITS),
    .DVS_BITS (CNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= FW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r <= cfg_data;
        REG_FRAME_HEIGHT: ;  // informational, not held
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.frame_clear) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.pix_en && !pix.last_pixel) begin
      if (col_wrap) begin
        col_r <= '0;
        row_r <= row_r + COORD_BITS'(1);
      end else begin
        col_r <= col_inc[COORD_BITS-1:0];
      end
    end
  end

  // raise the peak and restart the sums, or add a pixel at the peak while the count is not full
  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_class
    logic hit;
    assign hit = cmd.pix_en && pix.blue != '0 && cls == 1'(c);

    always_ff @(posedge clk) begin
      if (!rst_n || cmd.frame_clear) begin
        peak_r[c]    <= PEAK_RESET;
        col_sum_r[c] <= '0;
        row_sum_r[c] <= '0;
        cnt_r[c]     <= '0;
      end else if (hit) begin
        if (lvl > peak_r[c]) begin
          peak_r[c]    <= lvl;
          col_sum_r[c] <= col_ext;
          row_sum_r[c] <= row_ext;
          cnt_r[c]     <= CNT_BITS'(1);
        end else if (lvl == peak_r[c] && cnt_r[c] != '1) begin
          col_sum_r[c] <= col_sum_r[c] + col_ext;
          row_sum_r[c] <= row_sum_r[c] + row_ext;
          cnt_r[c]     <= cnt_r[c] + CNT_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      mean_r[cmd.job] <= quotient[OUT_BITS-1:0];
    end
    if (cmd.out_load) begin
      res_r.first_found  <= found0;
      res_r.first_col    <= found0 ? mean_r[0] : '0;
      res_r.first_row    <= found0 ? mean_r[1] : '0;
      res_r.second_found <= found1;
      res_r.second_col   <= found1 ? mean_r[2] : '0;
      res_r.second_row   <= found1 ? mean_r[3] : '0;
    end
  end

  assign sts.div_done = div_done;
  assign res          = res_r;

endmodule

`default_nettype wire

// ===== rtl/tcplc_ctrl.sv =====
// ---------------------------------------------------------------------------
// tcplc_ctrl
// Sequencer: pixel intake, four divisions per frame, result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module tcplc_ctrl
  import tcplc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire logic    in_last,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  state_t              state_r;
  state_t              state_nxt;
  logic [JOB_BITS-1:0] job_r;
  logic [JOB_BITS-1:0] job_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_PIX;
      job_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.job       = job_r;
    in_ready      = 1'b0;
    case (state_r)
      ST_PIX: begin
        in_ready   = 1'b1;
        cmd.pix_en = in_valid;
        if (in_valid && in_last) begin
          job_nxt   = '0;
          state_nxt = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (sts.div_done) begin
          cmd.res_load = 1'b1;
          job_nxt      = job_r + JOB_BITS'(1);
          state_nxt    = (job_r == LAST_JOB) ? ST_OUT : ST_DIV_START;
        end
      end
      ST_OUT: begin
        // hold until the previous word has gone
        if (!out_valid_r || out_ready) begin
          cmd.out_load    = 1'b1;
          cmd.frame_clear = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = ST_PIX;
        end
      end
      default: begin
        state_nxt = ST_PIX;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== tb/two_class_peak_level_centroid_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// two_class_peak_level_centroid_tb
// Streams RGB pixel frames into the centroid block under random sender
// bursts and receiver stalls. It predicts each frame's per-class found flag
// and mean column/row, and compares every result word field by field.
// Frame width and height are rewritten between frames, including the
// extreme widths.
// ---------------------------------------------------------------------------
`default_nettype none

module two_class_peak_level_centroid_tb;
  import tcplc_pkg::*;

  localparam int         DIV_LATENCY  = 4 * (3 * COORD_BITS_DEF + 3) + 1;
  localparam int         SETTLE_CYCLES = DIV_LATENCY + 16;
  localparam int         CYCLE_LIMIT  = 500000;
  localparam int         RANDOM_ITEMS = 780;
  localparam longint unsigned COUNT_LIMIT = (64'd1 << (2 * COORD_BITS_DEF + 1)) - 64'd1;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  pix_t                in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  res_t                out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_reg_t            cfg_index = REG_FRAME_WIDTH;
  logic [CFG_BITS-1:0] cfg_data  = '0;

  // predictor state
  logic [CFG_BITS-1:0]       frame_width;
  logic [CFG_BITS-1:0]       frame_height;
  logic [COORD_BITS_DEF-1:0] pix_col;
  logic [COORD_BITS_DEF-1:0] pix_row;
  logic [LEVEL_BITS-1:0]     peak_lvl [NUM_CLASSES];
  longint unsigned           col_sum  [NUM_CLASSES];
  longint unsigned           row_sum  [NUM_CLASSES];
  longint unsigned           hit_count[NUM_CLASSES];

  res_t centroid_queue[$];
  res_t want_res;
  int   fail_count  = 0;
  int   cycle_count = 0;
  int   burst_left  = 0;
  logic [15:0] ready_pattern = 16'hFFFF;
  logic [5:0]  ready_phase   = '0;

  two_class_peak_level_centroid u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("two_class_peak_level_centroid_tb: FAIL");
      $finish;
    end
  end

  // receiver: a fresh 16-bit stall pattern whenever the phase counter wraps, often none
  always @(posedge clk) begin
    ready_phase <= ready_phase + 6'd1;
    if (ready_phase == '0)
      ready_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    out_ready <= ready_pattern[ready_phase[3:0]];
  end

  task automatic clear_frame_state();
    for (int c = 0; c < NUM_CLASSES; c++) begin
      peak_lvl[c]  = PEAK_RESET;
      col_sum[c]   = 0;
      row_sum[c]   = 0;
      hit_count[c] = 0;
    end
    pix_col = '0;
    pix_row = '0;
  endtask

  function automatic logic [2*OUT_BITS:0] class_summary(int c);
    longint unsigned col_mean;
    longint unsigned row_mean;
    if (hit_count[c] == 0)
      return '0;
    col_mean = col_sum[c] / hit_count[c];
    row_mean = row_sum[c] / hit_count[c];
    return {1'b1, col_mean[OUT_BITS-1:0], row_mean[OUT_BITS-1:0]};
  endfunction

  task automatic track_pixel(pix_t p);
    int                    cls;
    logic [LEVEL_BITS-1:0] lvl;
    res_t                  r;
    if (p.blue != 8'd0) begin
      cls = (p.blue < BLUE_SPLIT) ? 0 : 1;
      lvl = (p.red[7:3] > p.green[7:3]) ? p.red[7:3] : p.green[7:3];
      // a higher level restarts the class at the new peak
      if (lvl > peak_lvl[cls]) begin
        peak_lvl[cls]  = lvl;
        col_sum[cls]   = 0;
        row_sum[cls]   = 0;
        hit_count[cls] = 0;
      end
      if (lvl == peak_lvl[cls] && hit_count[cls] < COUNT_LIMIT) begin
        col_sum[cls]   += pix_col;
        row_sum[cls]   += pix_row;
        hit_count[cls] += 1;
      end
    end
    if (p.last_pixel) begin
      {r.first_found, r.first_col, r.first_row}    = class_summary(0);
      {r.second_found, r.second_col, r.second_row} = class_summary(1);
      centroid_queue.push_back(r);
      clear_frame_state();
    end else if (int'(pix_col) + 1 >= int'(frame_width)) begin
      pix_col = '0;
      pix_row = pix_row + 1'b1;
    end else begin
      pix_col = pix_col + 1'b1;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (centroid_queue.size() == 0) begin
        $error("result word with no frame outstanding");
        fail_count++;
      end else begin
        want_res = centroid_queue.pop_front();
        if (out_data.first_found !== want_res.first_found) begin
          $error("first_found: expected %0d, actual %0d", want_res.first_found,
                 out_data.first_found);
          fail_count++;
        end
        if (out_data.first_col !== want_res.first_col) begin
          $error("first_col: expected %0d, actual %0d", want_res.first_col,
                 out_data.first_col);
          fail_count++;
        end
        if (out_data.first_row !== want_res.first_row) begin
          $error("first_row: expected %0d, actual %0d", want_res.first_row,
                 out_data.first_row);
          fail_count++;
        end
        if (out_data.second_found !== want_res.second_found) begin
          $error("second_found: expected %0d, actual %0d", want_res.second_found,
                 out_data.second_found);
          fail_count++;
        end
        if (out_data.second_col !== want_res.second_col) begin
          $error("second_col: expected %0d, actual %0d", want_res.second_col,
                 out_data.second_col);
          fail_count++;
        end
        if (out_data.second_row !== want_res.second_row) begin
          $error("second_row: expected %0d, actual %0d", want_res.second_row,
                 out_data.second_row);
          fail_count++;
        end
      end
    end
  end

  function automatic pix_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                      logic last);
    pix_t p;
    p.red        = r;
    p.green      = g;
    p.blue       = b;
    p.last_pixel = last;
    return p;
  endfunction

  // bias levels towards the reset peak and the top level so peaks get hit
  function automatic pix_t random_pixel(logic last);
    pix_t p;
    int   pick;
    pick = $urandom_range(0, 3);
    p = make_pixel(8'($urandom), 8'($urandom), 8'($urandom), last);
    if (pick == 1) begin
      p.red   = 8'($urandom_range(8, 15));
      p.green = 8'($urandom_range(0, 15));
    end else if (pick == 2) begin
      p.red = 8'($urandom_range(240, 255));
    end
    if ($urandom_range(0, 7) == 0)
      p.blue = 8'd0;
    return p;
  endfunction

  task automatic send_pixel(pix_t p);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    track_pixel(p);
  endtask

  task automatic send_frame(int len);
    for (int i = 1; i <= len; i++)
      send_pixel(random_pixel(i == len));
  endtask

  // hold the sender until every frame result is back and the block is quiet
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (centroid_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_FRAME_WIDTH)
      frame_width = val;
    else
      frame_height = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed_pixels();
    // neither class present
    send_pixel(make_pixel(8'd255, 8'd255, 8'd0, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b1));
    // reset peak, dropped low levels, raise to the top level, blue split
    send_pixel(make_pixel(8'd8, 8'd0, 8'd1, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd15, 8'd127, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd0, 8'd128, 1'b0));
    send_pixel(make_pixel(8'd7, 8'd7, 8'd255, 1'b0));
    send_pixel(make_pixel(8'd255, 8'd0, 8'd127, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd255, 8'd128, 1'b0));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b0));
    send_pixel(make_pixel(8'd248, 8'd0, 8'd1, 1'b0));
    send_pixel(make_pixel(8'd128, 8'd64, 8'd200, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b1));
    // one-pixel frame
    send_pixel(make_pixel(8'd16, 8'd0, 8'd200, 1'b1));
    // class one found on the last pixel itself
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd40, 8'd64, 1'b1));
    wait_idle();
  endtask

  task automatic test_width_settings();
    write_reg(REG_FRAME_WIDTH, 12'd1);
    write_reg(REG_FRAME_HEIGHT, 12'd0);
    send_frame(12);
    wait_idle();
    // zero width behaves as one pixel per row
    write_reg(REG_FRAME_WIDTH, 12'd0);
    write_reg(REG_FRAME_HEIGHT, 12'hFFF);
    send_frame(12);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 12'hFFF);
    write_reg(REG_FRAME_HEIGHT, 12'd2048);
    send_frame(12);
    wait_idle();
  endtask

  task automatic test_random_frames();
    int sent;
    int len;
    int width;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       width = 1;
        1:       width = 2;
        2:       width = 4095;
        3:       width = 2048;
        default: width = $urandom_range(1, 40);
      endcase
      write_reg(REG_FRAME_WIDTH, width[CFG_BITS-1:0]);
      if ($urandom_range(0, 1) == 1)
        write_reg(REG_FRAME_HEIGHT, CFG_BITS'($urandom));
      repeat ($urandom_range(1, 6)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
        send_frame(len);
        sent += len;
      end
      wait_idle();
    end
  endtask

  initial begin
    frame_width  = FW_RESET;
    frame_height = CFG_BITS'(480);
    clear_frame_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_pixels();
    test_width_settings();
    test_random_frames();
    if (fail_count == 0)
      $display("two_class_peak_level_centroid_tb: PASS");
    else
      $display("two_class_peak_level_centroid_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/tcplc_pkg.sv
rtl/tcplc_div.sv
rtl/tcplc_dp.sv
rtl/tcplc_ctrl.sv
rtl/two_class_peak_level_centroid.sv
tb/two_class_peak_level_centroid_tb.sv
